// ----- rtl/lsc_pkg.sv -----
// Package for the LSA structure checker: payload structs, error codes and
// header/body constants. It depends on nothing; every rtl file uses it.
package lsc_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        valid_res;
      logic [3:0]  error_code;
      logic [7:0]  lsa_type;
      logic [15:0] stated_length;
   } rsp_type;

   // Verdict handed from the parser to the result stage.
   typedef struct packed {
      logic [3:0]  code;
      logic [7:0]  lsa_type;
      logic [15:0] length;
   } verdict_type;

   localparam logic [3:0] ERR_OK         = 4'd0;
   localparam logic [3:0] ERR_SHORT      = 4'd1;
   localparam logic [3:0] ERR_LENGTH     = 4'd2;
   localparam logic [3:0] ERR_AGE        = 4'd3;
   localparam logic [3:0] ERR_ROUTER0    = 4'd4;
   localparam logic [3:0] ERR_SEQ        = 4'd5;
   localparam logic [3:0] ERR_TYPE       = 4'd6;
   localparam logic [3:0] ERR_ID         = 4'd7;
   localparam logic [3:0] ERR_RTR_SHORT  = 4'd8;
   localparam logic [3:0] ERR_LINK_FIT   = 4'd9;
   localparam logic [3:0] ERR_LINK_TYPE  = 4'd10;
   localparam logic [3:0] ERR_LINK_END   = 4'd11;
   localparam logic [3:0] ERR_NET_SHORT  = 4'd12;
   localparam logic [3:0] ERR_NET_WORD   = 4'd13;
   localparam int         ERR_LAST       = 13;
   localparam int         FAIL_W         = 14;

   localparam logic [16:0] COUNT_MAX      = 17'h1FFFF;
   localparam logic [16:0] HDR_BYTES      = 17'd20;
   localparam logic [15:0] HDR_BYTES16    = 16'd20;
   localparam logic [15:0] MAX_AGE_RESET  = 16'd3600;
   localparam logic [31:0] SEQ_RESERVED   = 32'h80000000;
   localparam logic [7:0]  TYPE_ROUTER    = 8'd1;
   localparam logic [7:0]  TYPE_NETWORK   = 8'd2;
   localparam logic [15:0] ROUTER_MIN_LEN = 16'd24;
   localparam logic [15:0] NET_MIN_LEN    = 16'd28;
   localparam logic [10:0] LINK_FIXED     = 11'd12;

endpackage

// ----- rtl/lsc_parser.sv -----
// Byte parser of the LSA structure checker: header capture, header checks,
// router link walk and network word checks. Depends on lsc_pkg.
module lsc_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  lsc_pkg::req_type     req,
   input  logic [15:0]          max_age,
   output lsc_pkg::verdict_type verdict
);

   logic [16:0] count_ff, count_in;
   logic [15:0] age_ff, age_in;
   logic [7:0]  type_ff, type_in;
   logic [31:0] lsid_ff, lsid_in;
   logic [31:0] adv_ff, adv_in;
   logic [31:0] seq_ff, seq_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] links_ff, links_in;
   logic [10:0] offset_ff, offset_in;
   logic [10:0] size_ff, size_in;
   logic        wnz_ff, wnz_in;
   logic [lsc_pkg::FAIL_W-1:0] fail_ff, fail_in;

   logic [7:0]  b;
   logic [15:0] p;
   logic [15:0] payload_len;
   logic [15:0] len_hdr;
   logic [15:0] links_new;
   logic [10:0] pos;
   logic [10:0] lsize_new;
   logic [16:0] room;
   logic [3:0]  code;

   always_comb begin
      count_in    = count_ff;
      age_in      = age_ff;
      type_in     = type_ff;
      lsid_in     = lsid_ff;
      adv_in      = adv_ff;
      seq_in      = seq_ff;
      len_in      = len_ff;
      links_in    = links_ff;
      offset_in   = offset_ff;
      size_in     = size_ff;
      wnz_in      = wnz_ff;
      fail_in     = fail_ff;
      b           = req.data_byte;
      p           = count_ff[15:0] - lsc_pkg::HDR_BYTES16;
      payload_len = len_ff - lsc_pkg::HDR_BYTES16;
      len_hdr     = {len_ff[15:8], b};
      links_new   = {links_ff[15:8], b};
      pos         = offset_ff;
      lsize_new   = lsc_pkg::LINK_FIXED + {1'b0, b, 2'b00};
      room        = {1'b0, payload_len} - {1'b0, p} + 17'd9;

      if (count_ff < lsc_pkg::COUNT_MAX) begin
         count_in = count_ff + 17'd1;
      end

      if (count_ff < lsc_pkg::HDR_BYTES) begin
         unique case (count_ff[4:0])
            5'd0:  age_in[15:8]   = b;
            5'd1:  age_in[7:0]    = b;
            5'd3:  type_in        = b;
            5'd4:  lsid_in[31:24] = b;
            5'd5:  lsid_in[23:16] = b;
            5'd6:  lsid_in[15:8]  = b;
            5'd7:  lsid_in[7:0]   = b;
            5'd8:  adv_in[31:24]  = b;
            5'd9:  adv_in[23:16]  = b;
            5'd10: adv_in[15:8]   = b;
            5'd11: adv_in[7:0]    = b;
            5'd12: seq_in[31:24]  = b;
            5'd13: seq_in[23:16]  = b;
            5'd14: seq_in[15:8]   = b;
            5'd15: seq_in[7:0]    = b;
            5'd18: len_in[15:8]   = b;
            5'd19: len_in[7:0]    = b;
            default: ;
         endcase
         // The last header byte completes the length, so checks use it directly.
         if (count_ff[4:0] == 5'd19) begin
            if (age_ff > max_age) fail_in[lsc_pkg::ERR_AGE] = 1'b1;
            if (adv_ff == 32'd0) fail_in[lsc_pkg::ERR_ROUTER0] = 1'b1;
            if (seq_ff == lsc_pkg::SEQ_RESERVED) fail_in[lsc_pkg::ERR_SEQ] = 1'b1;
            if (type_ff == lsc_pkg::TYPE_ROUTER) begin
               if (len_hdr < lsc_pkg::ROUTER_MIN_LEN) begin
                  fail_in[lsc_pkg::ERR_RTR_SHORT] = 1'b1;
               end else if (lsid_ff != adv_ff) begin
                  fail_in[lsc_pkg::ERR_ID] = 1'b1;
               end
            end else if (type_ff == lsc_pkg::TYPE_NETWORK) begin
               if (len_hdr < lsc_pkg::NET_MIN_LEN || len_hdr[1:0] != 2'd0) begin
                  fail_in[lsc_pkg::ERR_NET_SHORT] = 1'b1;
               end
            end else begin
               fail_in[lsc_pkg::ERR_TYPE] = 1'b1;
            end
         end
      end else if (count_ff < {1'b0, len_ff} && fail_ff == '0) begin
         if (type_ff == lsc_pkg::TYPE_ROUTER) begin
            if (p == 16'd2) begin
               links_in = {b, 8'd0};
            end else if (p == 16'd3) begin
               links_in  = links_new;
               offset_in = '0;
               size_in   = '0;
               if (links_new != 16'd0) begin
                  if (payload_len < 16'd16) fail_in[lsc_pkg::ERR_LINK_FIT] = 1'b1;
               end else if (payload_len != 16'd4) begin
                  fail_in[lsc_pkg::ERR_LINK_END] = 1'b1;
               end
            end else if (p >= 16'd4 && links_ff != 16'd0) begin
               if (pos == 11'd8 && (b < 8'd1 || b > 8'd4)) begin
                  fail_in[lsc_pkg::ERR_LINK_TYPE] = 1'b1;
               end else if (pos == 11'd9 && {6'd0, lsize_new} > room) begin
                  size_in = lsize_new;
                  fail_in[lsc_pkg::ERR_LINK_END] = 1'b1;
               end else begin
                  if (pos == 11'd9) size_in = lsize_new;
                  offset_in = pos + 11'd1;
                  // The link ends here: start the next one or require the body end.
                  if (pos >= 11'd11 && {1'b0, pos} + 12'd1 == {1'b0, size_ff}) begin
                     links_in  = links_ff - 16'd1;
                     offset_in = '0;
                     size_in   = '0;
                     if (links_ff != 16'd1) begin
                        if ({1'b0, p} + 17'd13 > {1'b0, payload_len}) begin
                           fail_in[lsc_pkg::ERR_LINK_FIT] = 1'b1;
                        end
                     end else if ({1'b0, p} + 17'd1 != {1'b0, payload_len}) begin
                        fail_in[lsc_pkg::ERR_LINK_END] = 1'b1;
                     end
                  end
               end
            end
         end else if (type_ff == lsc_pkg::TYPE_NETWORK && p >= 16'd4) begin
            if (p[1:0] == 2'd0) begin
               wnz_in = (b != 8'd0);
            end else begin
               wnz_in = wnz_ff || (b != 8'd0);
            end
            if (p[1:0] == 2'd3 && !wnz_in) fail_in[lsc_pkg::ERR_NET_WORD] = 1'b1;
         end
      end

      code = lsc_pkg::ERR_OK;
      if (count_in < lsc_pkg::HDR_BYTES) begin
         code = lsc_pkg::ERR_SHORT;
      end else if (count_in != {1'b0, len_in}) begin
         code = lsc_pkg::ERR_LENGTH;
      end else begin
         // Lowest set failure bit wins.
         for (int k = lsc_pkg::ERR_LAST; k >= int'(lsc_pkg::ERR_AGE); k--) begin
            if (fail_in[k]) code = 4'(k);
         end
      end
      verdict.code     = code;
      verdict.lsa_type = type_in;
      verdict.length   = len_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && req.last_byte)) begin
         count_ff  <= '0;
         age_ff    <= '0;
         type_ff   <= '0;
         lsid_ff   <= '0;
         adv_ff    <= '0;
         seq_ff    <= '0;
         len_ff    <= '0;
         links_ff  <= '0;
         offset_ff <= '0;
         size_ff   <= '0;
         wnz_ff    <= 1'b0;
         fail_ff   <= '0;
      end else if (step) begin
         count_ff  <= count_in;
         age_ff    <= age_in;
         type_ff   <= type_in;
         lsid_ff   <= lsid_in;
         adv_ff    <= adv_in;
         seq_ff    <= seq_in;
         len_ff    <= len_in;
         links_ff  <= links_in;
         offset_ff <= offset_in;
         size_ff   <= size_in;
         wnz_ff    <= wnz_in;
         fail_ff   <= fail_in;
      end
   end

   // A verdict always leaves the parser ready for a fresh LSA.
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step && req.last_byte |=> count_ff == '0 && fail_ff == '0)
      else $error("parser state not cleared after final byte");

endmodule

// ----- rtl/lsa_structure_check_core.sv -----
// Top level of the LSA structure checker: byte handshake, max_age register
// and result register. Depends on lsc_pkg and lsc_parser.
// Throughput: one byte per cycle; a byte is taken whenever the result
// register is empty or is being drained in the same cycle.
// Result: the verdict is in the result register in the cycle after the
// transfer of the final byte; the parser state is the only input register.
// Reset: synchronous; clears the parser state and result valid, and loads
// max_age with 3600.
module lsa_structure_check_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lsc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lsc_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_data
);

   logic [15:0]          max_age_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   lsc_pkg::rsp_type     rsp_data_ff, rsp_data_in;
   lsc_pkg::verdict_type verdict;
   logic                 req_fire;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   lsc_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (req_fire),
      .req     (req_data),
      .max_age (max_age_ff),
      .verdict (verdict)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_fire && req_data.last_byte) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.valid_res     = (verdict.code == lsc_pkg::ERR_OK);
         rsp_data_in.error_code    = verdict.code;
         rsp_data_in.lsa_type      = verdict.lsa_type;
         rsp_data_in.stated_length = verdict.length;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff   <= lsc_pkg::MAX_AGE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) max_age_ff <= csr_data;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.last_byte |=> rsp_valid_ff)
      else $error("no result after final byte transfer");

   a_valid_matches_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.valid_res == (rsp_data_ff.error_code == lsc_pkg::ERR_OK))
      else $error("valid_res disagrees with error_code");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.error_code <= lsc_pkg::ERR_NET_WORD)
      else $error("error_code out of range");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid_ff && !rsp_ready)
      else $error("input stalled while result register can take a result");

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the LSA structure checker: streams OSPFv2 LSAs byte by
// byte and compares every verdict with a cycle-free model of the parser.
// Depends on lsc_pkg and the lsa_structure_check_core RTL.
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASES = 6;
   localparam int PHASE_BYTES = 75;

   typedef enum int {
      FLAW_NONE, FLAW_TRUNCATE, FLAW_EXTRA, FLAW_LENGTH, FLAW_AGE, FLAW_ROUTER0,
      FLAW_SEQ, FLAW_TYPE, FLAW_ID, FLAW_LINK_TYPE, FLAW_LINK_COUNT, FLAW_TOS,
      FLAW_ZERO_WORD, FLAW_ODD_BODY, FLAW_NOISE
   } flaw_type;

   typedef struct {
      lsc_pkg::req_type item;
      bit               drain;
   } stim_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   lsc_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   lsc_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [15:0]      csr_data = '0;

   lsa_structure_check_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Stimulus and scoreboard storage.
   logic [7:0]       lsa_buf[$];
   stim_type         pending_bytes[$];
   lsc_pkg::rsp_type verdicts_due[$];
   int         req_total = 0;
   int         lsa_total = 0;
   int         bytes_taken = 0;
   int         csr_writes = 0;
   int         verdicts_seen = 0;
   int         fail_count = 0;
   int         cycles = 0;
   int         req_idle_pct = 0;
   int         rsp_idle_pct = 0;
   logic [15:0] gen_max_age = lsc_pkg::MAX_AGE_RESET;
   logic [15:0] codes_seen = '0;
   bit         req_took = 1'b0;
   bit         cur_drain = 1'b0;
   bit         hold_drain = 1'b0;

   // Model of the parser state.
   logic [15:0] max_age_m;
   logic [16:0] byte_cnt_m;
   logic [15:0] age_m;
   logic [7:0]  type_m;
   logic [31:0] lsid_m;
   logic [31:0] adv_m;
   logic [31:0] seq_m;
   logic [15:0] len_m;
   logic [15:0] links_m;
   logic [10:0] link_pos_m;
   logic [10:0] link_len_m;
   logic        word_nz_m;
   logic [lsc_pkg::FAIL_W-1:0] flags_m;

   function automatic void clear_parse();
      byte_cnt_m = '0;
      age_m = '0;
      type_m = '0;
      lsid_m = '0;
      adv_m = '0;
      seq_m = '0;
      len_m = '0;
      links_m = '0;
      link_pos_m = '0;
      link_len_m = '0;
      word_nz_m = 1'b0;
      flags_m = '0;
   endfunction

   // Called where the next router link would start; checks room for it or an exact end.
   function automatic void close_link(input int next, input int rest_len);
      link_pos_m = '0;
      link_len_m = '0;
      if (links_m != 0) begin
         if (next + 12 > rest_len)
            flags_m[lsc_pkg::ERR_LINK_FIT] = 1'b1;
      end else if (next != rest_len) begin
         flags_m[lsc_pkg::ERR_LINK_END] = 1'b1;
      end
   endfunction

   function automatic bit predict_verdict(input lsc_pkg::req_type item,
                                          output lsc_pkg::rsp_type verdict);
      int idx;
      int p;
      int rest_len;
      int pos;
      int size;
      int k;
      int b;
      logic [3:0] code;
      b = int'(item.data_byte);
      idx = int'(byte_cnt_m);
      verdict = '0;
      if (byte_cnt_m < lsc_pkg::COUNT_MAX)
         byte_cnt_m = byte_cnt_m + 17'd1;
      if (idx < 20) begin
         if (idx < 2)
            age_m[(1 - idx) * 8 +: 8] = item.data_byte;
         else if (idx == 3)
            type_m = item.data_byte;
         else if (idx >= 4 && idx < 8)
            lsid_m[(7 - idx) * 8 +: 8] = item.data_byte;
         else if (idx >= 8 && idx < 12)
            adv_m[(11 - idx) * 8 +: 8] = item.data_byte;
         else if (idx >= 12 && idx < 16)
            seq_m[(15 - idx) * 8 +: 8] = item.data_byte;
         else if (idx >= 18)
            len_m[(19 - idx) * 8 +: 8] = item.data_byte;
         if (idx == 19) begin
            if (age_m > max_age_m)
               flags_m[lsc_pkg::ERR_AGE] = 1'b1;
            if (adv_m == 0)
               flags_m[lsc_pkg::ERR_ROUTER0] = 1'b1;
            if (seq_m == lsc_pkg::SEQ_RESERVED)
               flags_m[lsc_pkg::ERR_SEQ] = 1'b1;
            if (type_m == lsc_pkg::TYPE_ROUTER) begin
               if (len_m < lsc_pkg::ROUTER_MIN_LEN)
                  flags_m[lsc_pkg::ERR_RTR_SHORT] = 1'b1;
               else if (lsid_m != adv_m)
                  flags_m[lsc_pkg::ERR_ID] = 1'b1;
            end else if (type_m == lsc_pkg::TYPE_NETWORK) begin
               if (len_m < lsc_pkg::NET_MIN_LEN || len_m[1:0] != 2'b00)
                  flags_m[lsc_pkg::ERR_NET_SHORT] = 1'b1;
            end else begin
               flags_m[lsc_pkg::ERR_TYPE] = 1'b1;
            end
         end
      end else if (idx < int'(len_m) && flags_m == 0) begin
         p = idx - 20;
         rest_len = int'(len_m) - 20;
         if (type_m == lsc_pkg::TYPE_ROUTER) begin
            if (p == 2) begin
               links_m = {item.data_byte, 8'h00};
            end else if (p == 3) begin
               links_m[7:0] = item.data_byte;
               close_link(4, rest_len);
            end else if (p >= 4 && links_m != 0) begin
               pos = int'(link_pos_m);
               size = 12 + b * 4;
               if (pos == 8 && (b < 1 || b > 4)) begin
                  flags_m[lsc_pkg::ERR_LINK_TYPE] = 1'b1;
               end else if (pos == 9 && size > rest_len - (p - 9)) begin
                  link_len_m = size[10:0];
                  flags_m[lsc_pkg::ERR_LINK_END] = 1'b1;
               end else begin
                  if (pos == 9)
                     link_len_m = size[10:0];
                  link_pos_m = 11'(pos + 1);
                  if (pos >= 11 && pos + 1 == int'(link_len_m)) begin
                     links_m = links_m - 16'd1;
                     close_link(p + 1, rest_len);
                  end
               end
            end
         end else if (type_m == lsc_pkg::TYPE_NETWORK && p >= 4) begin
            if (p % 4 == 0)
               word_nz_m = (b != 0);
            else
               word_nz_m = word_nz_m || (b != 0);
            if (p % 4 == 3 && !word_nz_m)
               flags_m[lsc_pkg::ERR_NET_WORD] = 1'b1;
         end
      end
      if (!item.last_byte)
         return 1'b0;
      if (byte_cnt_m < lsc_pkg::HDR_BYTES) begin
         code = lsc_pkg::ERR_SHORT;
      end else if (byte_cnt_m != {1'b0, len_m}) begin
         code = lsc_pkg::ERR_LENGTH;
      end else begin
         // The lowest failure code set wins.
         code = lsc_pkg::ERR_OK;
         for (k = lsc_pkg::ERR_LAST; k >= int'(lsc_pkg::ERR_AGE); k--)
            if (flags_m[k])
               code = k[3:0];
      end
      verdict.valid_res = (code == lsc_pkg::ERR_OK);
      verdict.error_code = code;
      verdict.lsa_type = type_m;
      verdict.stated_length = len_m;
      clear_parse();
      return 1'b1;
   endfunction

   // ---------------- Stimulus construction ----------------

   task automatic add_bytes(input logic [31:0] v, input int n);
      int i;
      for (i = n - 1; i >= 0; i--)
         lsa_buf.push_back(v[i * 8 +: 8]);
   endtask

   // Puts the 20-byte header in front of whatever body is already in the buffer.
   // A negative length means the stated length matches the finished LSA.
   task automatic add_header(input logic [15:0] age, input logic [7:0] typ,
                             input logic [31:0] lsid, input logic [31:0] adv,
                             input logic [31:0] seq, input int len);
      logic [7:0]  h[20];
      logic [15:0] stated;
      logic [15:0] cksum;
      int i;
      stated = (len < 0) ? 16'(lsa_buf.size() + 20) : 16'(len);
      cksum = 16'($urandom);
      h[0] = age[15:8];
      h[1] = age[7:0];
      h[2] = 8'($urandom);
      h[3] = typ;
      for (i = 0; i < 4; i++) begin
         h[4 + i] = lsid[(3 - i) * 8 +: 8];
         h[8 + i] = adv[(3 - i) * 8 +: 8];
         h[12 + i] = seq[(3 - i) * 8 +: 8];
      end
      h[16] = cksum[15:8];
      h[17] = cksum[7:0];
      h[18] = stated[15:8];
      h[19] = stated[7:0];
      for (i = 19; i >= 0; i--)
         lsa_buf.push_front(h[i]);
   endtask

   task automatic add_link(input logic [7:0] ltype, input logic [7:0] tos_field,
                           input int tos_entries);
      int i;
      add_bytes($urandom, 4);
      add_bytes($urandom, 4);
      add_bytes({24'd0, ltype}, 1);
      add_bytes({24'd0, tos_field}, 1);
      add_bytes($urandom, 2);
      for (i = 0; i < tos_entries; i++)
         add_bytes($urandom, 4);
   endtask

   task automatic send_lsa(input bit drain);
      stim_type s;
      int i;
      for (i = 0; i < lsa_buf.size(); i++) begin
         s.item.data_byte = lsa_buf[i];
         s.item.last_byte = (i == lsa_buf.size() - 1);
         s.drain = drain && s.item.last_byte;
         pending_bytes.push_back(s);
      end
      req_total += lsa_buf.size();
      lsa_total++;
      lsa_buf.delete();
   endtask

   task automatic directed_part();
      // Lone byte and a header cut one byte short.
      add_bytes(32'hFF, 1);
      send_lsa(1'b0);
      add_header(16'd10, lsc_pkg::TYPE_NETWORK, 32'd1, 32'd1, 32'd5, 28);
      void'(lsa_buf.pop_back());
      send_lsa(1'b0);
      // Clean router LSA at the age limit; the sender waits for its verdict.
      add_bytes(32'h0, 2);
      add_bytes(32'd1, 2);
      add_link(8'd4, 8'd0, 0);
      add_header(lsc_pkg::MAX_AGE_RESET, lsc_pkg::TYPE_ROUTER, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'h7FFF_FFFF, -1);
      send_lsa(1'b1);
      // Header failures, the first three each with a later one present to check the priority.
      add_bytes(32'd0, 4);
      add_header(lsc_pkg::MAX_AGE_RESET + 16'd1, lsc_pkg::TYPE_ROUTER, 32'd0, 32'd0,
                 32'd1, -1);
      send_lsa(1'b0);
      add_bytes(32'd0, 4);
      add_bytes(32'd1, 4);
      add_header(16'd0, lsc_pkg::TYPE_NETWORK, 32'd3, 32'd0, lsc_pkg::SEQ_RESERVED, -1);
      send_lsa(1'b0);
      add_header(16'd1, 8'd0, 32'd3, 32'd9, lsc_pkg::SEQ_RESERVED, -1);
      send_lsa(1'b0);
      add_header(16'd1, 8'hFF, 32'd3, 32'd9, 32'd2, -1);
      send_lsa(1'b0);
      // Router body too short is reported ahead of a link-state ID mismatch.
      add_bytes(32'h0102, 2);
      add_header(16'd1, lsc_pkg::TYPE_ROUTER, 32'd3, 32'd9, 32'd2, -1);
      send_lsa(1'b0);
      add_bytes(32'd0, 4);
      add_header(16'd1, lsc_pkg::TYPE_ROUTER, 32'd3, 32'd9, 32'd2, -1);
      send_lsa(1'b0);
      // Router with no links, then a link count with no room for the link.
      add_bytes(32'd0, 4);
      add_header(16'd1, lsc_pkg::TYPE_ROUTER, 32'd9, 32'd9, 32'd2, -1);
      send_lsa(1'b0);
      add_bytes(32'h0000_0001, 4);
      add_header(16'd1, lsc_pkg::TYPE_ROUTER, 32'd9, 32'd9, 32'd2, -1);
      send_lsa(1'b0);
      // Link types just outside the legal range.
      add_bytes(32'h0000_0001, 4);
      add_link(8'd0, 8'd0, 0);
      add_header(16'd1, lsc_pkg::TYPE_ROUTER, 32'd9, 32'd9, 32'd2, -1);
      send_lsa(1'b0);
      add_bytes(32'h0000_0001, 4);
      add_link(8'd5, 8'd0, 0);
      add_header(16'd1, lsc_pkg::TYPE_ROUTER, 32'd9, 32'd9, 32'd2, -1);
      send_lsa(1'b0);
      // A link that claims a TOS entry past the body, and links ending early.
      add_bytes(32'h0000_0001, 4);
      add_link(8'd1, 8'd1, 0);
      add_header(16'd1, lsc_pkg::TYPE_ROUTER, 32'd9, 32'd9, 32'd2, -1);
      send_lsa(1'b0);
      add_bytes(32'h0000_0001, 4);
      add_link(8'd2, 8'd0, 0);
      add_link(8'd3, 8'd0, 0);
      add_header(16'd1, lsc_pkg::TYPE_ROUTER, 32'd9, 32'd9, 32'd2, -1);
      send_lsa(1'b0);
      // Network LSAs: clean, age at the top, too short, length not a multiple of four, zero router word.
      add_bytes(32'hFFFF_FF00, 4);
      add_bytes(32'h0000_0001, 4);
      add_header(16'd0, lsc_pkg::TYPE_NETWORK, 32'd7, 32'd8, 32'd2, -1);
      send_lsa(1'b0);
      add_bytes(32'hFFFF_FF00, 4);
      add_bytes(32'h8000_0000, 4);
      add_header(16'hFFFF, lsc_pkg::TYPE_NETWORK, 32'd7, 32'd8, 32'd2, -1);
      send_lsa(1'b0);
      add_bytes(32'hFFFF_FF00, 4);
      add_header(16'd0, lsc_pkg::TYPE_NETWORK, 32'd7, 32'd8, 32'd2, -1);
      send_lsa(1'b0);
      add_bytes(32'hFFFF_FF00, 4);
      add_bytes(32'h0102_0304, 4);
      add_bytes(32'h0506, 2);
      add_header(16'd0, lsc_pkg::TYPE_NETWORK, 32'd7, 32'd8, 32'd2, -1);
      send_lsa(1'b0);
      add_bytes(32'hFFFF_FF00, 4);
      add_bytes(32'h0, 4);
      add_header(16'd0, lsc_pkg::TYPE_NETWORK, 32'd7, 32'd8, 32'd2, -1);
      send_lsa(1'b0);
      // Stated length that cannot match, and bytes running past the stated length.
      add_bytes(32'hFFFF_FF00, 4);
      add_header(16'd0, lsc_pkg::TYPE_NETWORK, 32'd7, 32'd8, 32'd2, 65535);
      send_lsa(1'b0);
      add_bytes(32'hFFFF_FF00, 4);
      add_bytes(32'h0000_0010, 4);
      add_bytes(32'h0000_0000, 4);
      add_header(16'd0, lsc_pkg::TYPE_NETWORK, 32'd7, 32'd8, 32'd2, 28);
      send_lsa(1'b0);
   endtask

   task automatic make_lsa(input flaw_type flaw);
      bit          router;
      int          nlinks;
      int          bad_at;
      int          tos;
      int          keep;
      int          i;
      logic [15:0] cnt;
      logic [7:0]  ltype;
      logic [7:0]  tos_field;
      logic [7:0]  typ;
      logic [15:0] age;
      logic [31:0] adv;
      logic [31:0] lsid;
      logic [31:0] seq;
      logic [31:0] w;
      int          len;
      if (flaw == FLAW_NOISE) begin
         keep = $urandom_range(1, 40);
         for (i = 0; i < keep; i++)
            add_bytes($urandom, 1);
         send_lsa(1'b0);
         return;
      end
      router = ($urandom_range(0, 1) == 1);
      if (flaw == FLAW_LINK_TYPE || flaw == FLAW_LINK_COUNT || flaw == FLAW_TOS ||
          flaw == FLAW_ID)
         router = 1'b1;
      if (flaw == FLAW_ZERO_WORD || flaw == FLAW_ODD_BODY)
         router = 1'b0;
      if (router) begin
         nlinks = (flaw == FLAW_LINK_TYPE || flaw == FLAW_TOS) ? $urandom_range(1, 3)
                                                               : $urandom_range(0, 3);
         bad_at = (nlinks > 0) ? $urandom_range(0, nlinks - 1) : 0;
         cnt = 16'(nlinks);
         if (flaw == FLAW_LINK_COUNT)
            cnt = $urandom_range(0, 1) ? cnt + 16'd1 : cnt - 16'd1;
         add_bytes($urandom, 2);
         add_bytes({16'd0, cnt}, 2);
         for (i = 0; i < nlinks; i++) begin
            ltype = 8'($urandom_range(1, 4));
            if (flaw == FLAW_LINK_TYPE && i == bad_at)
               ltype = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(5, 255));
            tos = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 40) : $urandom_range(0, 2);
            tos_field = 8'(tos);
            if (flaw == FLAW_TOS && i == bad_at)
               tos_field = (tos == 0 || $urandom_range(0, 1)) ? tos_field + 8'd1
                                                              : tos_field - 8'd1;
            add_link(ltype, tos_field, tos);
         end
      end else begin
         add_bytes($urandom, 4);
         nlinks = $urandom_range(1, 5);
         bad_at = $urandom_range(0, nlinks - 1);
         for (i = 0; i < nlinks; i++) begin
            w = ($urandom_range(0, 3) == 0) ? (32'h1 << $urandom_range(0, 31)) : $urandom;
            if (w == 0)
               w = 32'h1;
            if (flaw == FLAW_ZERO_WORD && i == bad_at)
               w = 32'h0;
            add_bytes(w, 4);
         end
         if (flaw == FLAW_ODD_BODY)
            add_bytes($urandom, $urandom_range(1, 3));
      end
      case ($urandom_range(0, 3))
         0: age = gen_max_age;
         1: age = 16'd0;
         default: age = 16'($urandom_range(0, gen_max_age));
      endcase
      if (flaw == FLAW_AGE && gen_max_age != 16'hFFFF)
         age = 16'($urandom_range(int'(gen_max_age) + 1, 65535));
      typ = router ? lsc_pkg::TYPE_ROUTER : lsc_pkg::TYPE_NETWORK;
      if (flaw == FLAW_TYPE)
         typ = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(3, 255));
      adv = $urandom;
      if (adv == 0)
         adv = 32'h1;
      if (flaw == FLAW_ROUTER0)
         adv = 32'h0;
      lsid = router ? adv : 32'($urandom);
      if (flaw == FLAW_ID)
         lsid = adv ^ (32'h1 << $urandom_range(0, 31));
      seq = $urandom;
      if (seq == lsc_pkg::SEQ_RESERVED)
         seq = 32'h1;
      if (flaw == FLAW_SEQ)
         seq = lsc_pkg::SEQ_RESERVED;
      len = lsa_buf.size() + 20;
      if (flaw == FLAW_LENGTH)
         len = len ^ (1 << $urandom_range(0, 15));
      add_header(age, typ, lsid, adv, seq, len);
      if (flaw == FLAW_TRUNCATE) begin
         keep = $urandom_range(1, lsa_buf.size() - 1);
         while (lsa_buf.size() > keep)
            void'(lsa_buf.pop_back());
      end
      if (flaw == FLAW_EXTRA)
         add_bytes($urandom, $urandom_range(1, 4));
      send_lsa($urandom_range(0, 9) == 0);
   endtask

   task automatic write_max_age(input logic [15:0] v);
      int target;
      target = csr_writes + 1;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      while (csr_writes != target)
         @(negedge clock);
      csr_valid <= 1'b0;
      gen_max_age = v;
   endtask

   task automatic wait_idle();
      while (bytes_taken != req_total || verdicts_due.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // ---------------- Driver ----------------

   always @(negedge clock) begin : drive_bytes
      stim_type nxt;
      if (req_took && cur_drain)
         hold_drain = 1'b1;
      if (hold_drain && verdicts_due.size() == 0)
         hold_drain = 1'b0;
      if (!reset && (!req_valid || req_took)) begin
         if (!hold_drain && pending_bytes.size() != 0 &&
             $urandom_range(0, 99) >= req_idle_pct) begin
            nxt = pending_bytes.pop_front();
            req_data <= nxt.item;
            cur_drain = nxt.drain;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= !reset && ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // ---------------- Monitor ----------------

   always @(posedge clock) begin : watch_ports
      lsc_pkg::rsp_type exp_v;
      lsc_pkg::rsp_type got_v;
      req_took <= req_valid && req_ready;
      if (reset) begin
         clear_parse();
         max_age_m = lsc_pkg::MAX_AGE_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            max_age_m = csr_data;
            csr_writes <= csr_writes + 1;
         end
         if (rsp_valid && rsp_ready) begin
            got_v = rsp_data;
            verdicts_seen++;
            codes_seen[got_v.error_code] = 1'b1;
            if (verdicts_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected verdict: valid=%0d code=%0d type=%0d len=%0d",
                           got_v.valid_res, got_v.error_code, got_v.lsa_type,
                           got_v.stated_length);
            end else begin
               exp_v = verdicts_due.pop_front();
               if (got_v.valid_res !== exp_v.valid_res ||
                   got_v.error_code !== exp_v.error_code ||
                   got_v.lsa_type !== exp_v.lsa_type ||
                   got_v.stated_length !== exp_v.stated_length) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("verdict mismatch: expected valid=%0d code=%0d type=%0d len=%0d,%s",
                              exp_v.valid_res, exp_v.error_code, exp_v.lsa_type,
                              exp_v.stated_length, "");
                  if (fail_count <= 10)
                     $display("                  got      valid=%0d code=%0d type=%0d len=%0d",
                              got_v.valid_res, got_v.error_code, got_v.lsa_type,
                              got_v.stated_length);
               end
            end
         end
         if (req_valid && req_ready) begin
            bytes_taken <= bytes_taken + 1;
            if (predict_verdict(req_data, exp_v))
               verdicts_due.push_back(exp_v);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------- Sequence of phases ----------------

   initial begin : run_phases
      int phase;
      int start;
      flaw_type flaw;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (phase = 0; phase < PHASES; phase++) begin
         // Sender light and receiver heavy, then the reverse, then no idling at all.
         case (phase / 2)
            0: begin
               req_idle_pct = 18;
               rsp_idle_pct = 76;
            end
            1: begin
               req_idle_pct = 76;
               rsp_idle_pct = 18;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         case (phase)
            0: directed_part();
            1: write_max_age(16'd0);
            2: write_max_age(16'hFFFF);
            4: write_max_age(16'd1);
            default: write_max_age(16'($urandom_range(0, 65535)));
         endcase
         start = req_total;
         while (req_total - start < PHASE_BYTES) begin
            flaw = FLAW_NONE;
            if ($urandom_range(0, 99) < 35)
               flaw = flaw_type'($urandom_range(1, FLAW_NOISE));
            make_lsa(flaw);
         end
         wait_idle();
      end
      $display("summary: %0d bytes in %0d LSAs over %0d phases, %0d verdicts checked",
               req_total, lsa_total, PHASES, verdicts_seen);
      $display("summary: error codes seen %b, %0d max_age writes, %0d mismatches",
               codes_seen, csr_writes, fail_count);
      if (fail_count == 0 && verdicts_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
